@@ rtl/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes of the min tracking stack
// operation kinds, status codes and the control words between the blocks
// ----------------------------------------------------------------------------
package mts_pkg;

    // operation kind carried on the input tuser
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status carried on the output tuser
    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // shift command for the cell chain
    typedef struct packed {
        logic push;   // every cell takes the entry from the cell above it
        logic pop;    // every cell takes the entry from the cell below it
    } t_shift_ctl;

    // sequencing strobes from the controller
    typedef struct packed {
        logic accept; // input word taken this cycle
        logic load;   // result register loads this cycle
    } t_seq_ctl;

endpackage

@@ rtl/mts_cell.sv @@
// ----------------------------------------------------------------------------
// mts_cell: one stack slot
// holds one stored entry and shifts with its neighbors on push and pop
// ----------------------------------------------------------------------------
module mts_cell #(
    parameter int ENTRY_WIDTH = 33
) (
    input  logic                   i_clk,
    input  mts_pkg::t_shift_ctl    i_ctl,
    input  logic [ENTRY_WIDTH-1:0] i_from_up,
    input  logic [ENTRY_WIDTH-1:0] i_from_down,
    output logic [ENTRY_WIDTH-1:0] o_entry
);

    logic [ENTRY_WIDTH-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_from_up;
        end else if (i_ctl.pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/mts_ctrl.sv @@
// ----------------------------------------------------------------------------
// mts_ctrl: item sequencer
// updates the stack when a word is accepted, then forms the result into the output word
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_m_tready,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    output mts_pkg::t_seq_ctl o_seq
);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_seq.accept = i_s_tvalid && (r_state == S_IDLE);
    assign o_seq.load   = (r_state == S_EVAL) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_seq.accept) n_state = S_EVAL;
            S_EVAL: if (o_seq.load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (o_seq.load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

@@ rtl/min_tracking_stack_core.sv @@
// ----------------------------------------------------------------------------
// min_tracking_stack_core: signed stack with constant-time minimum
// push/pop stack that reports top, minimum and empty flag after every word
// ----------------------------------------------------------------------------
// Each input word is a push of a signed value or a pop. Each accepted word
// gives exactly one output word holding the top value, the minimum value, an
// empty flag and a status (ok, push dropped because full, pop of an empty
// stack). An empty stack reports top 0 and minimum equal to the largest
// positive value. The stack is a row of STACK_DEPTH cells with the top entry
// always in cell 0: a push shifts every cell down by one, a pop shifts every
// cell up by one, so the top and the entry below it are always at fixed
// places and no memory read is needed. The bottom entry is stored raw; later
// entries hold value minus minimum at push time in DATA_WIDTH+1 bits, and a
// negative difference marks a minimum change that a pop undoes. An item first
// updates the cell chain, count and minimum, then forms the result from the
// updated top cell into the output register. No new word is taken until that
// result is loaded, but a new word is taken while a finished result still
// waits on the output. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack_core #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // input side
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,  // push_value, zero pad
    input  logic                                i_s_tuser,  // kind

    // output side
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]   o_m_tdata,  // top_value, min_value, pad
    output logic [2:0]                          o_m_tuser   // is_empty, status[1:0]
);

    localparam int ENTRY_W   = DATA_WIDTH + 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int OUT_DATA_W = ((2*DATA_WIDTH+7)/8)*8;
    localparam logic [DATA_WIDTH-1:0] EMPTY_MIN = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    mts_pkg::t_seq_ctl   w_seq;
    mts_pkg::t_shift_ctl w_shift;

    logic [ENTRY_W-1:0] w_entry [STACK_DEPTH];

    logic [CNT_W-1:0]      r_count;
    logic [DATA_WIDTH-1:0] r_min;
    logic [mts_pkg::STATUS_W-1:0] r_status;

    // result register
    logic [DATA_WIDTH-1:0] r_top_out, r_min_out;
    logic                  r_empty_out;
    logic [mts_pkg::STATUS_W-1:0] r_status_out;

    logic [DATA_WIDTH-1:0] w_val;
    logic                  w_is_pop, w_full, w_none;
    logic [ENTRY_W-1:0]    w_diff, w_push_entry;
    logic [DATA_WIDTH-1:0] w_top;

    // ------------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------------
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_seq      (w_seq)
    );

    // ------------------------------------------------------------------------
    // decode of the accepted word
    // ------------------------------------------------------------------------
    assign w_val    = i_s_tdata[DATA_WIDTH-1:0];
    assign w_is_pop = (i_s_tuser == mts_pkg::KIND_POP);
    assign w_full   = (r_count == CNT_W'(STACK_DEPTH));
    assign w_none   = (r_count == '0);

    // difference against current minimum, exact in one extra bit
    assign w_diff = {w_val[DATA_WIDTH-1], w_val} - {r_min[DATA_WIDTH-1], r_min};
    // bottom entry goes in raw
    assign w_push_entry = w_none ? {1'b0, w_val} : w_diff;

    assign w_shift.push = w_seq.accept && !w_is_pop && !w_full;
    assign w_shift.pop  = w_seq.accept &&  w_is_pop && !w_none;

    // ------------------------------------------------------------------------
    // cell chain, cell 0 is the top
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [ENTRY_W-1:0] w_up, w_down;
        if (g == 0) begin : g_top
            assign w_up = w_push_entry;
        end else begin : g_mid
            assign w_up = w_entry[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_down = w_entry[g];   // slot below the bottom is never read
        end else begin : g_up
            assign w_down = w_entry[g+1];
        end
        mts_cell #(
            .ENTRY_WIDTH (ENTRY_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_shift),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_entry     (w_entry[g])
        );
    end

    // ------------------------------------------------------------------------
    // count, minimum and status update
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_min    <= EMPTY_MIN;
            r_status <= mts_pkg::STATUS_OK;
        end else if (w_seq.accept) begin
            if (!w_is_pop) begin
                if (w_full) begin
                    r_status <= mts_pkg::STATUS_FULL;
                end else begin
                    r_status <= mts_pkg::STATUS_OK;
                    r_count  <= r_count + CNT_W'(1);
                    // first entry, or a new lower value
                    if (w_none || w_diff[DATA_WIDTH]) begin
                        r_min <= w_val;
                    end
                end
            end else begin
                if (w_none) begin
                    r_status <= mts_pkg::STATUS_EMPTY;
                end else begin
                    r_status <= mts_pkg::STATUS_OK;
                    r_count  <= r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        r_min <= EMPTY_MIN;
                    end else if (w_entry[0][DATA_WIDTH]) begin
                        // undo the minimum change made by this entry
                        r_min <= r_min - w_entry[0][DATA_WIDTH-1:0];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result forming from the updated top cell
    // ------------------------------------------------------------------------
    always_comb begin
        priority if (r_count == '0) begin
            w_top = '0;
        end else if (r_count == CNT_W'(1)) begin
            w_top = w_entry[0][DATA_WIDTH-1:0];
        end else if (w_entry[0][DATA_WIDTH]) begin
            w_top = r_min;
        end else begin
            w_top = r_min + w_entry[0][DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq.load) begin
            r_top_out    <= w_top;
            r_min_out    <= r_min;
            r_empty_out  <= (r_count == '0);
            r_status_out <= r_status;
        end
    end

    assign o_m_tdata = OUT_DATA_W'({r_min_out, r_top_out});
    assign o_m_tuser = {r_status_out, r_empty_out};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_min == EMPTY_MIN))
        else $error("minimum not restored on empty stack");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_seq.accept && !w_is_pop && w_full) |=>
            (r_status == mts_pkg::STATUS_FULL) && $stable(r_count))
        else $error("push to full stack not dropped");

    a_no_double_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_shift.push && w_shift.pop))
        else $error("push and pop shift in one cycle");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq.accept |=> w_seq.load || !o_s_tready)
        else $error("accepted word left without a result");

endmodule
